@@ hw/rtl/i2cme_pkg.sv @@
// Shared types and constants for the I2C master byte engine.
package i2cme_pkg;

	localparam int PHASE_W     = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] MODE_BEGIN = 2'd0;
	localparam logic [1:0] MODE_END   = 2'd1;
	localparam logic [1:0] MODE_WRITE = 2'd2;
	localparam logic [1:0] MODE_READ  = 2'd3;

	typedef struct packed {
		logic       cmd_valid;
		logic [1:0] mode;
		logic [7:0] wr_byte;
		logic       last_byte;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic       status;
		logic [7:0] rd_byte;
	} res_t;

	typedef struct packed {
		logic       is_start;
		logic       is_stop;
		logic       is_write;
		logic       is_read;
		logic [7:0] wr_byte;
		logic       last_byte;
		logic       sda_in;
	} op_t;

endpackage

@@ hw/rtl/i2cme_if.sv @@
// Valid/ready channel interfaces for item and result words.
interface i2cme_item_if;
	import i2cme_pkg::*;
	logic  valid;
	logic  ready;
	item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface i2cme_res_if;
	import i2cme_pkg::*;
	logic valid;
	logic ready;
	res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/i2cme_front.sv @@
// Front end: accept item words and decode the command into an operation word.
module i2cme_front (
	input  logic                clk,
	input  logic                arst_n,
	i2cme_item_if.sink          item,
	output logic                push_valid,
	input  logic                push_ready,
	output i2cme_pkg::op_t      push_op
);
	import i2cme_pkg::*;

	logic valid_s1;
	op_t  op_s1;
	op_t  op_dec;
	logic take;

	assign item.ready = !valid_s1 || push_ready;
	assign take       = item.valid && item.ready;

	always_comb begin
		op_dec           = '0;
		op_dec.wr_byte   = item.data.wr_byte;
		op_dec.last_byte = item.data.last_byte;
		op_dec.sda_in    = item.data.sda_in;
		if (item.data.cmd_valid) begin
			unique case (item.data.mode)
				MODE_BEGIN: op_dec.is_start = 1'b1;
				MODE_END:   op_dec.is_stop  = 1'b1;
				MODE_WRITE: op_dec.is_write = 1'b1;
				MODE_READ:  op_dec.is_read  = 1'b1;
				default:    op_dec.is_read  = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1 <= op_dec;
		end
	end

	assign push_valid = valid_s1;
	assign push_op    = op_s1;

endmodule

@@ hw/rtl/i2cme_fifo.sv @@
// Short queue of operation words between front end and sequencer.
module i2cme_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  i2cme_pkg::op_t      push_op,
	output logic                pop_valid,
	input  logic                pop_ready,
	output i2cme_pkg::op_t      pop_op
);
	import i2cme_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	op_t           mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign push_ready = (count_q != CW'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_op     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

@@ hw/rtl/i2cme_back.sv @@
// Sequencer: run bus phases per tick and register the result word.
module i2cme_back #(
	parameter int TICK_COUNT_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [i2cme_pkg::PHASE_W-1:0]      cfg_wdata,
	input  logic                               pop_valid,
	output logic                               pop_ready,
	input  i2cme_pkg::op_t                     pop_op,
	i2cme_res_if.source                        res
);
	import i2cme_pkg::*;

	localparam int TW = TICK_COUNT_WIDTH;
	localparam int LW = (TW > PHASE_W) ? TW : PHASE_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_STOP  = 3'd2;
	localparam logic [2:0] ST_WRITE = 3'd3;
	localparam logic [2:0] ST_READ  = 3'd4;

	logic [PHASE_W-1:0] phase_ticks_q;
	logic [2:0]         state_q, state_n;
	logic [1:0]         phase_q, phase_n;
	logic [3:0]         bit_q, bit_n, bit_inc;
	logic [7:0]         shift_q, shift_n;
	logic [TW-1:0]      tick_q, tick_n, tick_inc, limit;
	logic               scl_q, scl_n, sda_q, sda_n;
	logic               nack_q, nack_n, status_q, status_n;
	logic [7:0]         rdres_q, rdres_n;
	logic               done;
	logic               fin;
	logic               pop;
	logic               res_valid_q;
	res_t               res_q;
	logic [LW-1:0]      pt_ext, cnt_max, lim_ext;

	assign pop_ready = !res_valid_q || res.ready;
	assign pop       = pop_valid && pop_ready;

	always_comb begin
		pt_ext  = LW'(phase_ticks_q);
		cnt_max = (LW'(1) << TW) - LW'(1);
		if (pt_ext == '0) begin
			lim_ext = LW'(1);
		end else if (pt_ext > cnt_max) begin
			lim_ext = cnt_max;
		end else begin
			lim_ext = pt_ext;
		end
		limit = lim_ext[TW-1:0];
	end

	always_comb begin
		state_n  = state_q;
		phase_n  = phase_q;
		bit_n    = bit_q;
		shift_n  = shift_q;
		tick_n   = tick_q;
		scl_n    = scl_q;
		sda_n    = sda_q;
		nack_n   = nack_q;
		status_n = status_q;
		rdres_n  = rdres_q;
		done     = 1'b0;
		fin      = 1'b0;
		tick_inc = tick_q + TW'(1);
		bit_inc  = bit_q + 4'd1;
		if (state_q == ST_IDLE) begin
			if (pop_op.is_start || pop_op.is_stop || pop_op.is_write || pop_op.is_read) begin
				phase_n = '0;
				bit_n   = '0;
				tick_n  = '0;
			end
			if (pop_op.is_start) begin
				state_n = ST_START;
				sda_n   = 1'b1;
			end else if (pop_op.is_stop) begin
				state_n = ST_STOP;
				scl_n   = 1'b1;
			end else if (pop_op.is_write) begin
				state_n = ST_WRITE;
				shift_n = pop_op.wr_byte;
				nack_n  = 1'b0;
				sda_n   = pop_op.wr_byte[7];
				scl_n   = 1'b1;
			end else if (pop_op.is_read) begin
				state_n = ST_READ;
				shift_n = '0;
				nack_n  = pop_op.last_byte;
				sda_n   = 1'b1;
				scl_n   = 1'b1;
			end
		end else if (tick_inc >= limit) begin
			tick_n = '0;
			unique case (state_q)
				ST_START: begin
					case (phase_q)
						2'd0: scl_n = 1'b1;
						2'd1: sda_n = 1'b0;
						2'd2: scl_n = 1'b0;
						default: begin
							status_n = 1'b0;
							fin      = 1'b1;
						end
					endcase
					phase_n = phase_q + 2'd1;
				end
				ST_STOP: begin
					if (phase_q == 2'd0) begin
						sda_n   = 1'b1;
						phase_n = 2'd1;
					end else begin
						status_n = 1'b0;
						fin      = 1'b1;
					end
				end
				default: begin
					case (phase_q)
						2'd0: begin
							if (bit_q < 4'd8) begin
								shift_n = {shift_q[6:0], pop_op.sda_in};
							end else if (state_q == ST_WRITE) begin
								nack_n = pop_op.sda_in;
							end
							phase_n = 2'd1;
						end
						2'd1: begin
							scl_n   = 1'b0;
							phase_n = 2'd2;
						end
						2'd2: begin
							sda_n   = 1'b0;
							phase_n = 2'd3;
						end
						default: begin
							bit_n = bit_inc;
							if (bit_inc >= 4'd9) begin
								if (state_q == ST_WRITE) begin
									status_n = nack_q;
								end else begin
									status_n = 1'b0;
									rdres_n  = shift_q;
								end
								fin = 1'b1;
							end else begin
								phase_n = 2'd0;
								scl_n   = 1'b1;
								if (bit_inc < 4'd8) begin
									sda_n = (state_q == ST_WRITE) ? shift_q[7] : 1'b1;
								end else begin
									sda_n = (state_q == ST_WRITE) ? 1'b1 : nack_q;
								end
							end
						end
					endcase
				end
			endcase
			if (fin) begin
				state_n = ST_IDLE;
				phase_n = '0;
				bit_n   = '0;
				done    = 1'b1;
			end
		end else begin
			tick_n = tick_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_W'(1);
		end else if (cfg_we) begin
			phase_ticks_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= '0;
			bit_q       <= '0;
			shift_q     <= '0;
			tick_q      <= '0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			nack_q      <= 1'b0;
			status_q    <= 1'b0;
			rdres_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				state_q     <= state_n;
				phase_q     <= phase_n;
				bit_q       <= bit_n;
				shift_q     <= shift_n;
				tick_q      <= tick_n;
				scl_q       <= scl_n;
				sda_q       <= sda_n;
				nack_q      <= nack_n;
				status_q    <= status_n;
				rdres_q     <= rdres_n;
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.scl_out  <= scl_n;
			res_q.sda_out  <= sda_n;
			res_q.busy_res <= (state_n != ST_IDLE);
			res_q.done_res <= done;
			res_q.status   <= status_n;
			res_q.rd_byte  <= rdres_n;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

endmodule

@@ hw/rtl/i2c_master_byte_engine_top.sv @@
// Top level of the I2C master byte engine.
// Usage:
//   item   : one word per bus tick, carrying the sampled SDA level and an
//            optional command (start, stop, write byte, read byte).
//   result : one word per item with the SCL/SDA drive levels, busy, done
//            pulse, status and the last received byte.
//   cfg_we/cfg_wdata : phase_ticks, ticks per quarter-bit phase; write only
//            while the engine is idle and all results are taken.
// An accepted item passes through the decode stage, the two-entry queue and
// the result register before its result word appears.
// Throughput is one word per cycle while results are taken; the sequencer
// updates its state once per item as it moves into the result register.
// Reset: engine idle, SCL and SDA released, phase_ticks = 1, queue empty.
// When the result receiver stalls, the result register holds, the decode
// stage and queue take up to three more words, then item ready drops.
module i2c_master_byte_engine_top #(
	parameter int TICK_COUNT_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	i2cme_item_if.sink                    item,
	i2cme_res_if.source                   result,
	input  logic                          cfg_we,
	input  logic [i2cme_pkg::PHASE_W-1:0] cfg_wdata
);
	import i2cme_pkg::*;

	logic push_valid;
	logic push_ready;
	op_t  push_op;
	logic pop_valid;
	logic pop_ready;
	op_t  pop_op;

	i2cme_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_op    (push_op)
	);

	i2cme_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_op    (push_op),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_op     (pop_op)
	);

	i2cme_back #(
		.TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_op    (pop_op),
		.res       (result)
	);

endmodule
